// File: src/ort_pkg.sv
`default_nettype none

package ort_pkg;

   localparam int ID_W = 32;
   localparam int STATUS_W = 32;
   localparam int COUNT_W = 32;
   localparam int OUTSTANDING_W = 7;

   // Command codes of an input item
   localparam logic CMD_ISSUE = 1'b0;
   localparam logic CMD_REPLY = 1'b1;

   typedef enum logic [2:0] {
      KIND_ISSUED       = 3'd0,
      KIND_FULL         = 3'd1,
      KIND_IN_ORDER     = 3'd2,
      KIND_OUT_OF_ORDER = 3'd3,
      KIND_UNMATCHED    = 3'd4
   } kind_type;

   typedef struct packed {
      logic                       command;
      logic                       awaited;
      logic                       expects_body;
      logic [ID_W-1:0]            reply_id;
      logic signed [STATUS_W-1:0] reply_status;
   } req_type;

   typedef struct packed {
      kind_type                   kind;
      logic [ID_W-1:0]            txn_id;
      logic                       was_awaited;
      logic                       carried_result;
      logic signed [STATUS_W-1:0] status;
      logic [OUTSTANDING_W-1:0]   outstanding;
      logic [COUNT_W-1:0]         sent_count;
      logic [COUNT_W-1:0]         retired_count;
      logic [COUNT_W-1:0]         read_count;
      logic [COUNT_W-1:0]         out_of_order_count;
      logic [COUNT_W-1:0]         unmatched_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic            expects_body;
      logic            awaited;
   } entry_type;

endpackage

`default_nettype wire

// File: src/outstanding_request_tracker_core.sv
`default_nettype none

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_type
// rsp      out        rsp_valid/rsp_stall  rsp_type
//
// Issue: accept, then result. Full reject: accept, then result.
// Reply: the entry table has one read and one write port, so the id scan
// reads one entry at a time up to the match, and closing the gap moves each
// entry behind it one slot lower, one entry at a time.
// reset clears counts and control; table contents need no clearing.
// req_stall is high while an item is in work; a stalled result holds.

module outstanding_request_tracker_core
   import ort_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [ID_W-1:0] next_id_ff, next_id_in;
   logic [COUNT_W-1:0] sent_ff, sent_in;
   logic [COUNT_W-1:0] retired_ff, retired_in;
   logic [COUNT_W-1:0] read_ff, read_in;
   logic [COUNT_W-1:0] ooo_ff, ooo_in;
   logic [COUNT_W-1:0] unmatched_ff, unmatched_in;

   logic [ID_W-1:0] reply_id_ff, reply_id_in;
   logic signed [STATUS_W-1:0] reply_status_ff, reply_status_in;

   logic [CNT_W-1:0] scan_ff, scan_in;
   logic chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0] mv_ff, mv_in;
   logic wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;

   kind_type res_kind_ff, res_kind_in;
   logic [ID_W-1:0] res_id_ff, res_id_in;
   logic res_aw_ff, res_aw_in;
   logic res_res_ff, res_res_in;
   logic signed [STATUS_W-1:0] res_status_ff, res_status_in;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic load;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type rd_data;
   logic [CNT_W+OUTSTANDING_W-1:0] total_ext;

   ort_entry_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign total_ext = {{OUTSTANDING_W{1'b0}}, total_ff};

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      next_id_in = next_id_ff;
      sent_in = sent_ff;
      retired_in = retired_ff;
      read_in = read_ff;
      ooo_in = ooo_ff;
      unmatched_in = unmatched_ff;
      reply_id_in = reply_id_ff;
      reply_status_in = reply_status_ff;
      scan_in = scan_ff;
      chk_in = chk_ff;
      chk_idx_in = chk_idx_ff;
      mv_in = mv_ff;
      wr_pend_in = wr_pend_ff;
      wr_idx_in = wr_idx_ff;
      res_kind_in = res_kind_ff;
      res_id_in = res_id_ff;
      res_aw_in = res_aw_ff;
      res_res_in = res_res_ff;
      res_status_in = res_status_ff;
      wr_en = 1'b0;
      wr_addr = total_ff[IDX_W-1:0];
      wr_data = '{id: next_id_ff, expects_body: req_data.expects_body,
                  awaited: req_data.awaited};
      rd_addr = scan_ff[IDX_W-1:0];
      load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_ISSUE) begin
                  res_status_in = '0;
                  if (total_ff == DEPTH_C) begin
                     res_kind_in = KIND_FULL;
                     res_id_in = '0;
                     res_aw_in = 1'b0;
                     res_res_in = 1'b0;
                  end else begin
                     wr_en = 1'b1;
                     total_in = total_ff + CNT_W'(1);
                     next_id_in = next_id_ff + ID_W'(1);
                     if (!req_data.awaited) begin
                        sent_in = sent_ff + COUNT_W'(1);
                     end
                     res_kind_in = KIND_ISSUED;
                     res_id_in = next_id_ff;
                     res_aw_in = req_data.awaited;
                     res_res_in = req_data.expects_body;
                  end
                  state_in = ST_FINISH;
               end else begin
                  reply_id_in = req_data.reply_id;
                  reply_status_in = req_data.reply_status;
                  scan_in = '0;
                  chk_in = 1'b0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (chk_ff && rd_data.id == reply_id_ff) begin
               // head match retires in order, anything later out of order
               if (chk_idx_ff == '0) begin
                  res_kind_in = KIND_IN_ORDER;
               end else begin
                  res_kind_in = KIND_OUT_OF_ORDER;
                  ooo_in = ooo_ff + COUNT_W'(1);
               end
               retired_in = retired_ff + COUNT_W'(1);
               if (rd_data.expects_body && reply_status_ff == '0) begin
                  read_in = read_ff + COUNT_W'(1);
               end
               res_id_in = reply_id_ff;
               res_aw_in = rd_data.awaited;
               res_res_in = rd_data.expects_body;
               res_status_in = reply_status_ff;
               mv_in = CNT_W'(chk_idx_ff) + CNT_W'(1);
               wr_pend_in = 1'b0;
               chk_in = 1'b0;
               state_in = ST_SHIFT;
            end else if (scan_ff < total_ff) begin
               chk_in = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end else if (!chk_ff) begin
               unmatched_in = unmatched_ff + COUNT_W'(1);
               res_kind_in = KIND_UNMATCHED;
               res_id_in = reply_id_ff;
               res_aw_in = 1'b0;
               res_res_in = 1'b0;
               res_status_in = '0;
               state_in = ST_FINISH;
            end else begin
               chk_in = 1'b0;
            end
         end
         ST_SHIFT: begin
            // read one entry ahead, write it one slot lower next cycle
            if (wr_pend_ff) begin
               wr_en = 1'b1;
               wr_addr = wr_idx_ff;
               wr_data = rd_data;
            end
            rd_addr = mv_ff[IDX_W-1:0];
            if (mv_ff < total_ff) begin
               wr_pend_in = 1'b1;
               wr_idx_in = mv_ff[IDX_W-1:0] - IDX_W'(1);
               mv_in = mv_ff + CNT_W'(1);
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  total_in = total_ff - CNT_W'(1);
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

      rsp_data_in.kind = res_kind_ff;
      rsp_data_in.txn_id = res_id_ff;
      rsp_data_in.was_awaited = res_aw_ff;
      rsp_data_in.carried_result = res_res_ff;
      rsp_data_in.status = res_status_ff;
      rsp_data_in.outstanding = total_ext[OUTSTANDING_W-1:0];
      rsp_data_in.sent_count = sent_ff;
      rsp_data_in.retired_count = retired_ff;
      rsp_data_in.read_count = read_ff;
      rsp_data_in.out_of_order_count = ooo_ff;
      rsp_data_in.unmatched_count = unmatched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         next_id_ff <= ID_W'(1);
         sent_ff <= '0;
         retired_ff <= '0;
         read_ff <= '0;
         ooo_ff <= '0;
         unmatched_ff <= '0;
         chk_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         next_id_ff <= next_id_in;
         sent_ff <= sent_in;
         retired_ff <= retired_in;
         read_ff <= read_in;
         ooo_ff <= ooo_in;
         unmatched_ff <= unmatched_in;
         chk_ff <= chk_in;
         wr_pend_ff <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reply_id_ff <= reply_id_in;
      reply_status_ff <= reply_status_in;
      scan_ff <= scan_in;
      chk_idx_ff <= chk_idx_in;
      mv_ff <= mv_in;
      wr_idx_ff <= wr_idx_in;
      res_kind_ff <= res_kind_in;
      res_id_ff <= res_id_in;
      res_aw_ff <= res_aw_in;
      res_res_ff <= res_res_in;
      res_status_ff <= res_status_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ort_entry_ram.sv
`default_nettype none

module ort_entry_ram
   import ort_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire              clock,
   input  wire              wr_en,
   input  wire [ADDR_W-1:0] wr_addr,
   input  wire entry_type   wr_data,
   input  wire [ADDR_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
